>>> hw/rtl/mbrot_pkg.sv
// Shared types and constants for the multibrot escape-time pixel engine.
`timescale 1ns / 1ps

package mbrot_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_POWER    = 3'd0;
	localparam logic [2:0] REG_OFF_RE   = 3'd1;
	localparam logic [2:0] REG_OFF_IM   = 3'd2;
	localparam logic [2:0] REG_INV_ZOOM = 3'd3;
	localparam logic [2:0] REG_MAX_IT   = 3'd4;
	localparam logic [2:0] REG_CACHE_IT = 3'd5;
	localparam logic [2:0] REG_HALF_W   = 3'd6;
	localparam logic [2:0] REG_HALF_H   = 3'd7;

	// Exponent codes.
	localparam logic [1:0] POW_2 = 2'd0;
	localparam logic [1:0] POW_3 = 2'd1;
	localparam logic [1:0] POW_4 = 2'd2;

	// Iteration engine states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP_MUL,
		ST_MAP_ADD,
		ST_SQ,
		ST_TEST,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_UPD,
		ST_DONE
	} eng_state_t;

	// Saturate a 66-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		begin
			hi = 66'sd2147483647;
			lo = -66'sd2147483648;
			if (v > hi) begin
				sat32 = 32'sh7fffffff;
			end else if (v < lo) begin
				sat32 = 32'sh80000000;
			end else begin
				sat32 = v[31:0];
			end
		end
	endfunction

endpackage

>>> hw/rtl/mbrot_front.sv
// Front end: accepts pixels, classifies them and forms the job queue entry.
`timescale 1ns / 1ps

module mbrot_front
	import mbrot_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int COORD_WIDTH = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [COORD_WIDTH-1:0]        pix_x,
	input  logic [COORD_WIDTH-1:0]        pix_y,
	input  logic                          refine,
	input  logic [COUNT_WIDTH-1:0]        prev_iters,
	input  logic signed [31:0]            prev_zr,
	input  logic signed [31:0]            prev_zi,
	input  logic [COUNT_WIDTH-1:0]        cache_limit,
	output logic                          job_valid,
	input  logic                          job_take,
	output logic [2*COORD_WIDTH+COUNT_WIDTH+65:0] job_data
);

	localparam int JW = 2*COORD_WIDTH + COUNT_WIDTH + 66;

	// Two-entry job queue.
	logic [JW-1:0] mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          skip;

	assign in_stall  = (cnt_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign skip      = refine && (prev_iters != cache_limit);
	assign job_data  = mem_q[rp_q];

	// Queue write and pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (job_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= {skip, refine, pix_x, pix_y, prev_iters, prev_zr, prev_zi};
		end
	end

endmodule

>>> hw/rtl/mbrot_engine.sv
// Back end: maps a pixel to c and iterates z = z^p + c with one multiplier.
`timescale 1ns / 1ps

module mbrot_engine
	import mbrot_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int FRAC_BITS   = 26,
	parameter int COORD_WIDTH = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_take,
	input  logic [2*COORD_WIDTH+COUNT_WIDTH+65:0] job_data,
	input  logic [1:0]                    power_mode,
	input  logic signed [31:0]            view_re,
	input  logic signed [31:0]            view_im,
	input  logic [30:0]                   zoom_step,
	input  logic [COUNT_WIDTH-1:0]        iter_limit,
	input  logic [11:0]                   half_width,
	input  logic [11:0]                   half_height,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          skipped,
	output logic [COUNT_WIDTH-1:0]        iter_count,
	output logic signed [31:0]            final_zr,
	output logic signed [31:0]            final_zi
);

	// Offsets from the screen center need room for both coordinate and half size.
	localparam int DW = ((COORD_WIDTH > 12) ? COORD_WIDTH : 12) + 2;

	eng_state_t state_q, state_d;

	logic signed [31:0] zr_q, zi_q, cr_q, ci_q, zr2_q, zi2_q;
	logic signed [31:0] ta_q, tb_q, tc_q;
	logic [COUNT_WIDTH-1:0] it_q;
	logic refine_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [1:0] step_q;
	logic signed [65:0] acc_q;

	// Fields of the queue entry.
	logic j_skip, j_ref;
	logic [COORD_WIDTH-1:0] j_px, j_py;
	logic [COUNT_WIDTH-1:0] j_it;
	logic signed [31:0] j_zr, j_zi;
	assign {j_skip, j_ref, j_px, j_py, j_it, j_zr, j_zi} = job_data;

	// Shared Q multiplier: floor shift and saturate.
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [31:0] qprod;
	assign prod  = ma * mb;
	assign qprod = sat32(66'(prod >>> FRAC_BITS));

	// Map products are exact integers.
	logic signed [65:0] map_re, map_im;
	assign map_re = 66'(dx_q) * 66'($signed({1'b0, zoom_step})) + 66'(view_re);
	assign map_im = 66'(dy_q) * 66'($signed({1'b0, zoom_step})) + 66'(view_im);

	logic signed [65:0] four;
	assign four = 66'sd4 <<< FRAC_BITS;
	logic escape;
	assign escape = (66'(zr2_q) + 66'(zi2_q) >= four) || (it_q >= iter_limit);

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign job_take = (state_q == ST_IDLE) && job_valid && !(j_skip && !out_free);

	// Operand select for the multiplier.
	always_comb begin
		ma = zr_q;
		mb = zr_q;
		case (state_q)
			ST_SQ: begin
				ma = (step_q == 2'd0) ? zr_q : zi_q;
				mb = ma;
			end
			ST_P1: begin
				ma = zr_q;
				mb = zi_q;
			end
			ST_P2: begin
				case (power_mode)
					POW_3: begin
						ma = (step_q == 2'd0) ? zi_q : zr_q;
						mb = (step_q == 2'd0) ? ta_q : tb_q;
					end
					default: begin
						ma = (step_q == 2'd0) ? ta_q : zr2_q;
						mb = (step_q == 2'd0) ? tb_q : zr2_q;
					end
				endcase
			end
			ST_P3: begin
				ma = (step_q == 2'd0) ? zr2_q : zi2_q;
				mb = zi2_q;
			end
			default: begin
				ma = zr_q;
				mb = zr_q;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (job_take) state_d = j_skip ? ST_IDLE : ST_MAP_MUL;
			ST_MAP_MUL: state_d = ST_MAP_ADD;
			ST_MAP_ADD: state_d = ST_SQ;
			ST_SQ: if (step_q == 2'd1) state_d = ST_TEST;
			ST_TEST: state_d = escape ? ST_DONE : ST_P1;
			ST_P1: state_d = ST_P2;
			ST_P2: begin
				if (power_mode == POW_4) begin
					if (step_q == 2'd1) state_d = ST_P3;
				end else if (power_mode == POW_3) begin
					if (step_q == 2'd1) state_d = ST_UPD;
				end else begin
					state_d = ST_UPD;
				end
			end
			ST_P3: if (step_q == 2'd1) state_d = ST_UPD;
			ST_UPD: state_d = ST_SQ;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			step_q    <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) step_q <= 2'd0;
			else step_q <= step_q + 2'd1;
			// A new result replaces a taken one; otherwise a taken result clears.
			if ((state_q == ST_DONE && out_free) || (job_take && j_skip)) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (job_take) begin
					refine_q <= j_ref;
					it_q     <= j_ref ? j_it : '0;
					zr_q     <= j_zr;
					zi_q     <= j_zi;
					dx_q     <= $signed(DW'(j_px)) - $signed(DW'(half_width));
					dy_q     <= $signed(DW'(half_height)) - $signed(DW'(j_py));
				end
				if (job_take && j_skip) begin
					skipped    <= 1'b1;
					iter_count <= '0;
					final_zr   <= '0;
					final_zi   <= '0;
				end
			end
			ST_MAP_MUL: begin
				cr_q <= sat32(map_re);
				ci_q <= sat32(map_im);
			end
			ST_MAP_ADD: begin
				if (!refine_q) begin
					zr_q <= cr_q;
					zi_q <= ci_q;
				end
			end
			ST_SQ: begin
				if (step_q == 2'd0) zr2_q <= qprod;
				else zi2_q <= qprod;
			end
			ST_P1: begin
				case (power_mode)
					POW_3: begin
						ta_q <= sat32(66'sd3 * 66'(zr2_q) - 66'(zi2_q));
						tb_q <= sat32(66'(zr2_q) - 66'sd3 * 66'(zi2_q));
					end
					default: begin
						ta_q <= qprod;
						tb_q <= sat32(66'(zr2_q) - 66'(zi2_q));
					end
				endcase
			end
			ST_P2: begin
				case (power_mode)
					POW_3: begin
						if (step_q == 2'd0) tc_q <= qprod;
						else acc_q <= 66'(qprod);
					end
					POW_4: begin
						if (step_q == 2'd0) tc_q <= qprod;
						else acc_q <= 66'(qprod);
					end
					default: begin
						tc_q  <= sat32(66'sd2 * 66'(ta_q));
						acc_q <= 66'(zr2_q) - 66'(zi2_q);
					end
				endcase
			end
			ST_P3: begin
				if (step_q == 2'd0) acc_q <= acc_q - 66'sd6 * 66'(qprod);
				else acc_q <= acc_q + 66'(qprod);
			end
			ST_UPD: begin
				if (power_mode == POW_4) begin
					zi_q <= sat32(66'sd4 * 66'(tc_q) + 66'(ci_q));
				end else if (power_mode == POW_3) begin
					zi_q <= sat32(66'(tc_q) + 66'(ci_q));
				end else begin
					zi_q <= sat32(66'sd2 * 66'(ta_q) + 66'(ci_q));
				end
				zr_q <= sat32(acc_q + 66'(cr_q));
				it_q <= it_q + COUNT_WIDTH'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					skipped    <= 1'b0;
					iter_count <= it_q;
					final_zr   <= zr_q;
					final_zi   <= zi_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/multibrot_escape_time_pixel.sv
// Top level of the multibrot escape-time pixel engine.
// Usage:
// A pixel transfer on the input channel (in_valid high, in_stall low) carries
// its position, the refine flag and the cached count and z. One result
// transfer on the output channel follows per pixel, in order.
// A two-entry queue separates the front end from the iteration engine, so
// pixels are taken while the engine is busy until the queue is full.
// A skipped pixel is queued, then offered from the result register. A computed
// pixel is mapped (multiply, add), then iterates through square, test, product
// and update states, z^4 adding a third product state; the single shared
// multiplier sets this sequence. Throughput: one pixel iterates at a time and
// holds the engine; skipped pixels pass at one per cycle while out_stall is low.
// Configuration writes are taken every cycle and must be made while idle.
// Reset empties the queue and loads the register reset values.
// While out_stall is high the result holds and the engine waits after
// finishing its pixel; the queue still accepts up to two pixels.
`timescale 1ns / 1ps

module multibrot_escape_time_pixel
	import mbrot_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int FRAC_BITS   = 26,
	parameter int COORD_WIDTH = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] pix_x,
	input  logic [COORD_WIDTH-1:0] pix_y,
	input  logic                   refine,
	input  logic [COUNT_WIDTH-1:0] prev_iters,
	input  logic signed [31:0]     prev_zr,
	input  logic signed [31:0]     prev_zi,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   skipped,
	output logic [COUNT_WIDTH-1:0] iter_count,
	output logic signed [31:0]     final_zr,
	output logic signed [31:0]     final_zi,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	logic [1:0]             power_q;
	logic signed [31:0]     off_re_q, off_im_q;
	logic [30:0]            inv_zoom_q;
	logic [COUNT_WIDTH-1:0] max_it_q, cache_it_q;
	logic [11:0]            half_w_q, half_h_q;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q    <= POW_2;
			off_re_q   <= '0;
			off_im_q   <= '0;
			inv_zoom_q <= 31'(64'd1 << FRAC_BITS);
			max_it_q   <= COUNT_WIDTH'(255);
			cache_it_q <= '0;
			half_w_q   <= '0;
			half_h_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POWER:    power_q    <= cfg_data[1:0];
				REG_OFF_RE:   off_re_q   <= cfg_data;
				REG_OFF_IM:   off_im_q   <= cfg_data;
				REG_INV_ZOOM: inv_zoom_q <= cfg_data[30:0];
				REG_MAX_IT:   max_it_q   <= COUNT_WIDTH'(cfg_data[15:0]);
				REG_CACHE_IT: cache_it_q <= COUNT_WIDTH'(cfg_data[15:0]);
				REG_HALF_W:   half_w_q   <= cfg_data[11:0];
				REG_HALF_H:   half_h_q   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	logic job_valid, job_take;
	logic [2*COORD_WIDTH+COUNT_WIDTH+65:0] job_data;

	mbrot_front #(.COUNT_WIDTH(COUNT_WIDTH), .COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .pix_x, .pix_y, .refine,
		.prev_iters, .prev_zr, .prev_zi, .cache_limit(cache_it_q),
		.job_valid, .job_take, .job_data
	);

	mbrot_engine #(
		.COUNT_WIDTH(COUNT_WIDTH), .FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)
	) u_engine (
		.clk, .arst_n, .job_valid, .job_take, .job_data,
		.power_mode(power_q), .view_re(off_re_q), .view_im(off_im_q),
		.zoom_step(inv_zoom_q), .iter_limit(max_it_q),
		.half_width(half_w_q), .half_height(half_h_q),
		.out_valid, .out_stall, .skipped, .iter_count, .final_zr, .final_zi
	);

endmodule

>>> hw/rtl/mbrot_checker.sv
// Port-level checker for the multibrot pixel engine, bound to the top level.
`timescale 1ns / 1ps

module mbrot_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        skipped,
	input logic [15:0] iter_count,
	input logic [31:0] final_zr,
	input logic        cfg_ready
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(iter_count) && $stable(final_zr))
		else $error("result changed under stall");

	// A skipped result carries zero count and zero z.
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skipped |-> iter_count == 16'd0 && final_zr == 32'd0)
		else $error("skipped result not cleared");

	// Configuration is always taken.
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind multibrot_escape_time_pixel mbrot_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .skipped,
	.iter_count(iter_count[15:0]), .final_zr, .cfg_ready
);
